[rtl/aifp_pkg.sv]
`default_nettype none

package aifp_pkg;

  // longest field in characters
  localparam int unsigned FIELD_MAX = 32;
  localparam int unsigned CNT_W = 6;

  // conversion register codes
  localparam logic [2:0] CONV_SDEC = 3'd0;
  localparam logic [2:0] CONV_AUTO = 3'd1;
  localparam logic [2:0] CONV_OCT  = 3'd2;
  localparam logic [2:0] CONV_UDEC = 3'd3;
  localparam logic [2:0] CONV_HEX  = 3'd4;

  // characters with a role of their own
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,  // expecting sign or first char
    PH_SIGNED = 2'd1,  // sign taken
    PH_ZERO   = 2'd2,  // leading zero taken
    PH_DIGITS = 2'd3   // in the digit run
  } phase_t;

  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_8    = 2'd1,
    BASE_10   = 2'd2,
    BASE_16   = 2'd3
  } base_t;

  // running state of one field, as seen by the result formatter
  typedef struct packed {
    logic [31:0]      acc;
    logic             negative;
    logic             digit_seen;
    logic             overflowed;
    logic [CNT_W-1:0] count;
  } field_t;

  typedef struct packed {
    logic [31:0]      value;
    logic             failed;
    logic             stored;
    logic             char_returned;
    logic [CNT_W-1:0] chars_used;
  } result_t;

  // base selected by a conversion code; unused codes read as hex
  function automatic base_t conv_base(input logic [2:0] conv);
    base_t b;
    case (conv)
      CONV_SDEC: b = BASE_10;
      CONV_AUTO: b = BASE_AUTO;
      CONV_OCT:  b = BASE_8;
      CONV_UDEC: b = BASE_10;
      default:   b = BASE_16;
    endcase
    return b;
  endfunction

  // digit value of a character: bit 4 set means not a digit in any base
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    if (c inside {[8'h30:8'h39]}) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = {1'b0, 4'(c - 8'h57)};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = {1'b0, 4'(c - 8'h37)};
    end else begin
      d = 5'h10;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/aifp_if.sv]
`default_nettype none

// character channel
interface aifp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

// result channel
interface aifp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        failed;
  logic        stored;
  logic        char_returned;
  logic [5:0]  chars_used;

  modport source (output valid, output value, output failed, output stored,
                  output char_returned, output chars_used, input ready);
  modport sink   (input valid, input value, input failed, input stored,
                  input char_returned, input chars_used, output ready);
endinterface

`default_nettype wire

[rtl/aifp_finish.sv]
`default_nettype none

// Turns the state of a finished field into the result word:
// range check, sign, saturation and short truncation.
module aifp_finish (
  input  var aifp_pkg::field_t  field,
  input  var logic [2:0]        conversion,
  input  var logic              half_size,
  input  var logic              suppress,
  input  var logic              returned,
  output var aifp_pkg::result_t result
);

  logic        is_signed;
  logic        range_err;
  logic [31:0] signed_val;
  logic [31:0] conv_val;
  logic        fail;

  assign is_signed  = (conversion == aifp_pkg::CONV_SDEC) ||
                      (conversion == aifp_pkg::CONV_AUTO);
  assign signed_val = field.negative ? (32'd0 - field.acc) : field.acc;

  // signed range: up to 2^31-1, or 2^31 with a minus sign
  assign range_err = field.overflowed ||
                     (!field.negative && field.acc[31]) ||
                     (field.negative && field.acc[31] && (field.acc[30:0] != 31'd0));

  always_comb begin
    fail     = !field.digit_seen;
    conv_val = 32'd0;
    if (!fail && !suppress) begin
      if (is_signed) begin
        if (range_err) begin
          fail = 1'b1;
        end else begin
          conv_val = signed_val;
        end
      end else begin
        conv_val = field.overflowed ? 32'hFFFF_FFFF : signed_val;
      end
      if (half_size) begin
        conv_val = {16'd0, conv_val[15:0]};
      end
    end
  end

  assign result.value         = conv_val;
  assign result.failed        = fail;
  assign result.stored        = !fail && !suppress;
  assign result.char_returned = returned;
  assign result.chars_used    = field.count;

endmodule

`default_nettype wire

[rtl/ascii_integer_field_parser.sv]
`default_nettype none

// ASCII integer field parser (scanf-style integer conversion).
// in_ch carries one character word per handshake (char_code, end_of_input);
// out_ch carries one result word per finished field (value, failed,
// stored, char_returned, chars_used). Characters that continue a field
// give no word. The cfg_ APB port holds conversion (0x0), max_width (0x4),
// half_size (0x8) and suppress (0xC); write them only while idle.
// Timing: a character is taken into the input register at the accepting
// edge and processed there against the field state; a result it causes
// is written into the result register as that word leaves the input one.
// Throughput is one character per cycle, but a field-ending character
// waits while the result register is full; it is set by the update of
// the field state (constant-base shift-add accumulator).
// A field that ends on a character it cannot use reports char_returned;
// that character is dropped and the next word starts a new field.
// Reset (rst_n low, synchronous) clears valid flags, config registers and field state.
// When out_ch stalls, the result is held; a character that would end a
// field waits in the input register and in_ch.ready drops, while
// characters that only extend a field still move through.
module ascii_integer_field_parser (
  input  var logic        clk,
  input  var logic        rst_n,
  aifp_in_if.sink         in_ch,
  aifp_out_if.source      out_ch,
  input  var logic        cfg_psel,
  input  var logic        cfg_penable,
  input  var logic        cfg_pwrite,
  input  var logic [3:0]  cfg_paddr,
  input  var logic [31:0] cfg_pwdata,
  output var logic [31:0] cfg_prdata,
  output var logic        cfg_pready
);

  localparam logic [1:0] REG_CONVERSION = 2'd0;
  localparam logic [1:0] REG_MAX_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HALF_SIZE  = 2'd2;
  localparam logic [1:0] REG_SUPPRESS   = 2'd3;

  localparam logic [aifp_pkg::CNT_W-1:0] FIELD_LIMIT = aifp_pkg::CNT_W'(aifp_pkg::FIELD_MAX);

  // configuration registers
  logic [2:0] conversion_r;
  logic [5:0] max_width_r;
  logic       half_size_r;
  logic       suppress_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_eof_r;

  // field state
  aifp_pkg::phase_t phase_r, phase_nxt;
  aifp_pkg::base_t  base_r, base_nxt;
  aifp_pkg::field_t field_r, field_nxt, field_upd;

  // result register
  logic              out_valid_r;
  aifp_pkg::result_t out_r;
  aifp_pkg::result_t result;

  logic                       advance;
  logic                       emit;
  logic                       returned;
  logic                       consumed;
  logic [aifp_pkg::CNT_W-1:0] limit;
  aifp_pkg::base_t            base_cur;
  aifp_pkg::base_t            base_dig;
  logic [4:0]                 dig;
  logic                       dig_ok;
  logic [36:0]                acc_ext;
  logic [36:0]                prod;
  logic [aifp_pkg::CNT_W-1:0] count_inc;

  // APB write/read
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conversion_r <= aifp_pkg::CONV_SDEC;
      max_width_r  <= 6'd0;
      half_size_r  <= 1'b0;
      suppress_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CONVERSION: conversion_r <= cfg_pwdata[2:0];
        REG_MAX_WIDTH:  max_width_r  <= cfg_pwdata[5:0];
        REG_HALF_SIZE:  half_size_r  <= cfg_pwdata[0];
        REG_SUPPRESS:   suppress_r   <= cfg_pwdata[0];
        default:        suppress_r   <= suppress_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CONVERSION: cfg_prdata = {29'd0, conversion_r};
      REG_MAX_WIDTH:  cfg_prdata = {26'd0, max_width_r};
      REG_HALF_SIZE:  cfg_prdata = {31'd0, half_size_r};
      REG_SUPPRESS:   cfg_prdata = {31'd0, suppress_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // handshakes: the input register moves unless its word must emit into a full output
  assign advance      = s1_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_code;
      s1_eof_r  <= in_ch.end_of_input;
    end
  end

  // width limit: 0 or too large means the longest field
  assign limit = ((max_width_r == 6'd0) || (max_width_r > FIELD_LIMIT)) ?
                 FIELD_LIMIT : max_width_r;

  // accumulate one digit in the resolved base
  assign base_cur = (phase_r == aifp_pkg::PH_START) ?
                    aifp_pkg::conv_base(conversion_r) : base_r;
  assign base_dig = (base_cur != aifp_pkg::BASE_AUTO) ? base_cur :
                    ((phase_r == aifp_pkg::PH_ZERO) ? aifp_pkg::BASE_8 : aifp_pkg::BASE_10);
  assign dig      = aifp_pkg::digit_of(s1_char_r);
  assign acc_ext  = {5'd0, field_r.acc};
  assign count_inc = field_r.count + 6'd1;

  always_comb begin
    case (base_dig)
      aifp_pkg::BASE_8:  dig_ok = !dig[4] && (dig[3] == 1'b0);
      aifp_pkg::BASE_10: dig_ok = !dig[4] && (dig[3:0] <= 4'd9);
      aifp_pkg::BASE_16: dig_ok = !dig[4];
      default:           dig_ok = 1'b0;
    endcase
    case (base_dig)
      aifp_pkg::BASE_8:  prod = (acc_ext << 3) + {33'd0, dig[3:0]};
      aifp_pkg::BASE_10: prod = (acc_ext << 3) + (acc_ext << 1) + {33'd0, dig[3:0]};
      default:           prod = (acc_ext << 4) + {33'd0, dig[3:0]};
    endcase
  end

  // next state of the field and the end-of-field decision
  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_cur;
    field_upd = field_r;
    consumed  = 1'b0;
    emit      = 1'b0;
    returned  = 1'b0;
    if (field_r.count >= limit) begin
      emit     = 1'b1;
      returned = !s1_eof_r;
    end else if (s1_eof_r) begin
      emit = 1'b1;
    end else begin
      if ((phase_r == aifp_pkg::PH_START) &&
          ((s1_char_r == aifp_pkg::CH_PLUS) || (s1_char_r == aifp_pkg::CH_MINUS))) begin
        field_upd.negative = (s1_char_r == aifp_pkg::CH_MINUS);
        phase_nxt          = aifp_pkg::PH_SIGNED;
        consumed           = 1'b1;
      end else if (((phase_r == aifp_pkg::PH_START) || (phase_r == aifp_pkg::PH_SIGNED)) &&
                   (s1_char_r == aifp_pkg::CH_ZERO)) begin
        field_upd.digit_seen = 1'b1;
        phase_nxt            = aifp_pkg::PH_ZERO;
        consumed             = 1'b1;
      end else if ((phase_r == aifp_pkg::PH_ZERO) &&
                   ((s1_char_r == aifp_pkg::CH_X_LO) || (s1_char_r == aifp_pkg::CH_X_UP)) &&
                   ((base_cur == aifp_pkg::BASE_AUTO) || (base_cur == aifp_pkg::BASE_16))) begin
        base_nxt  = aifp_pkg::BASE_16;
        phase_nxt = aifp_pkg::PH_DIGITS;
        consumed  = 1'b1;
      end else begin
        base_nxt  = base_dig;
        phase_nxt = aifp_pkg::PH_DIGITS;
        if (dig_ok) begin
          // saturate the magnitude once it leaves 32 bits
          if (prod[36:32] != 5'd0) begin
            field_upd.overflowed = 1'b1;
            field_upd.acc        = 32'hFFFF_FFFF;
          end else begin
            field_upd.acc = prod[31:0];
          end
          field_upd.digit_seen = 1'b1;
          consumed             = 1'b1;
        end
      end
      if (!consumed) begin
        emit     = 1'b1;
        returned = 1'b1;
      end else begin
        field_upd.count = count_inc;
        if (count_inc >= limit) begin
          emit = 1'b1;
        end
      end
    end
    field_nxt = field_upd;
    if (emit) begin
      phase_nxt = aifp_pkg::PH_START;
      field_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= aifp_pkg::PH_START;
      base_r  <= aifp_pkg::BASE_10;
      field_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      field_r <= field_nxt;
    end
  end

  aifp_finish u_finish (
    .field      (field_upd),
    .conversion (conversion_r),
    .half_size  (half_size_r),
    .suppress   (suppress_r),
    .returned   (returned),
    .result     (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.value         = out_r.value;
  assign out_ch.failed        = out_r.failed;
  assign out_ch.stored        = out_r.stored;
  assign out_ch.char_returned = out_r.char_returned;
  assign out_ch.chars_used    = out_r.chars_used;

`ifndef SYNTHESIS
  // the consumed count never passes the longest field
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    field_r.count <= FIELD_LIMIT)
    else $error("field count beyond limit");

  // a finished field leaves a fresh field behind
  a_field_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit |=> (phase_r == aifp_pkg::PH_START) && (field_r.count == '0) &&
                        !field_r.digit_seen)
    else $error("field state not cleared after result");

  // magnitude stays zero until a digit is seen
  a_acc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !field_r.digit_seen |-> (field_r.acc == 32'd0))
    else $error("accumulator moved without a digit");

  // a failed field is never stored and reads as zero
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.failed |-> !out_r.stored && (out_r.value == 32'd0))
    else $error("failed result stored or nonzero");

  // a word that must emit is held while the result register is full
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_char_r))
    else $error("stalled character lost");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aifp_pkg::*;

  // register map, one 32-bit word per register
  typedef enum logic [1:0] {
    REG_CONVERSION = 2'd0,
    REG_MAX_WIDTH  = 2'd1,
    REG_HALF_SIZE  = 2'd2,
    REG_SUPPRESS   = 2'd3
  } cfg_reg_t;

  // receiver ready patterns
  typedef enum int {
    STALL_NONE   = 0,
    STALL_LIGHT  = 1,
    STALL_HEAVY  = 2,
    STALL_TOGGLE = 3
  } stall_mode_t;

  // highest conversion code; the spare codes above hex read as unsigned hex
  localparam logic [2:0] CONV_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 6;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES  = 200;

  logic clk = 1'b0;
  logic rst_n;

  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  aifp_in_if  in_if ();
  aifp_out_if out_if ();

  ascii_integer_field_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register copies and running field state of the parser
  logic [2:0]  cfg_conv;
  logic [5:0]  cfg_width;
  logic        cfg_half;
  logic        cfg_supp;
  phase_t      fld_phase;
  int          fld_radix;
  logic [63:0] fld_mag;
  logic        fld_neg;
  logic        fld_digits;
  logic        fld_ovf;
  logic [5:0]  fld_count;

  result_t expected_results[$];
  int mismatches = 0;
  int sent_chars = 0;
  int burst_left = 0;
  int hold_request = 0;

  // numeric base of a conversion code, 0 for auto
  function automatic int conv_radix(input logic [2:0] conv);
    int r;
    case (conv)
      CONV_SDEC, CONV_UDEC: r = 10;
      CONV_AUTO:            r = 0;
      CONV_OCT:             r = 8;
      default:              r = 16;
    endcase
    return r;
  endfunction

  // digit value in the given base, -1 if the char cannot continue the field
  function automatic int char_digit(input logic [7:0] c, input int radix);
    int d;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    else d = -1;
    return (d < radix) ? d : -1;
  endfunction

  function automatic void start_field();
    fld_phase  = PH_START;
    fld_radix  = conv_radix(cfg_conv);
    fld_mag    = '0;
    fld_neg    = 1'b0;
    fld_digits = 1'b0;
    fld_ovf    = 1'b0;
    fld_count  = '0;
  endfunction

  // close the field and queue the result word it gives
  function automatic void end_field(input logic returned);
    result_t r;
    logic fail;
    logic [31:0] val;
    fail = !fld_digits;
    val = '0;
    if (!fail && !cfg_supp) begin
      if (cfg_conv <= CONV_AUTO) begin
        // signed: range check, negative side may reach 2^31
        if (fld_ovf || (!fld_neg && fld_mag > 64'h7FFF_FFFF) ||
            (fld_neg && fld_mag > 64'h8000_0000)) begin
          fail = 1'b1;
        end else begin
          val = fld_neg ? -fld_mag[31:0] : fld_mag[31:0];
        end
      end else if (fld_ovf) begin
        val = '1;
      end else begin
        val = fld_neg ? -fld_mag[31:0] : fld_mag[31:0];
      end
      if (fail) val = '0;
      if (cfg_half) val[31:16] = '0;
    end
    r.value         = val;
    r.failed        = fail;
    r.stored        = !fail && !cfg_supp;
    r.char_returned = returned;
    r.chars_used    = fld_count;
    expected_results.push_back(r);
    start_field();
  endfunction

  // advance the field state by one accepted char word
  function automatic void take_char(input logic [7:0] c, input logic eoi);
    int limit;
    int d;
    logic used;
    limit = (cfg_width == 0 || cfg_width > FIELD_MAX) ? FIELD_MAX : cfg_width;
    used = 1'b0;
    if (fld_count >= limit) begin
      // limit lowered under a running field: this word ends it unused
      end_field(!eoi);
    end else if (eoi) begin
      end_field(1'b0);
    end else begin
      if (fld_phase == PH_START) fld_radix = conv_radix(cfg_conv);
      if (fld_phase == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
        fld_neg = (c == CH_MINUS);
        fld_phase = PH_SIGNED;
        used = 1'b1;
      end else if ((fld_phase == PH_START || fld_phase == PH_SIGNED) && c == CH_ZERO) begin
        fld_digits = 1'b1;
        fld_phase = PH_ZERO;
        used = 1'b1;
      end else if (fld_phase == PH_ZERO && (c == CH_X_LO || c == CH_X_UP) &&
                   (fld_radix == 0 || fld_radix == 16)) begin
        fld_radix = 16;
        fld_phase = PH_DIGITS;
        used = 1'b1;
      end else begin
        // auto base settles on the first char after the optional zero
        if (fld_radix == 0) fld_radix = (fld_phase == PH_ZERO) ? 8 : 10;
        fld_phase = PH_DIGITS;
        d = char_digit(c, fld_radix);
        if (d >= 0) begin
          fld_mag = fld_mag * fld_radix + d;
          if (fld_mag > 64'hFFFF_FFFF) begin
            fld_ovf = 1'b1;
            fld_mag = 64'hFFFF_FFFF;
          end
          fld_digits = 1'b1;
          used = 1'b1;
        end
      end
      if (!used) begin
        end_field(1'b1);
      end else begin
        fld_count++;
        if (fld_count >= limit) end_field(1'b0);
      end
    end
  endfunction

  // random digit, mostly valid in the current base
  function automatic logic [7:0] digit_char();
    int radix;
    int idx;
    logic [7:0] c;
    radix = conv_radix(cfg_conv);
    if (radix == 0) radix = 10;
    if ($urandom_range(0, 7) == 0) radix = 16;
    idx = $urandom_range(0, radix - 1);
    c = (idx < 10) ? 8'(8'h30 + idx) : 8'(8'h61 + idx - 10);
    if (idx >= 10 && $urandom_range(0, 1) == 1) c = c - 8'h20;
    return c;
  endfunction

  // literals at the signed and unsigned range edges
  function automatic string range_literal(input int k);
    string s;
    case (k)
      0:       s = "2147483647";
      1:       s = "2147483648";
      2:       s = "4294967295";
      3:       s = "4294967296";
      4:       s = "0x7fffffff";
      5:       s = "0X80000000";
      6:       s = "FFFFFFFF";
      default: s = "37777777777";
    endcase
    return s;
  endfunction

  // one char word; bursts of random length with random gaps between them
  task automatic send_char(input logic [7:0] c, input logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.char_code    <= c;
    in_if.end_of_input <= eoi;
    do @(posedge clk); while (!in_if.ready);
    take_char(c, eoi);
    sent_chars++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_char(8'($urandom), 1'b1);
  endtask

  // no word offered, all results in, pipeline drained
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register
  task automatic reg_write(input cfg_reg_t r, input logic [31:0] data);
    logic [31:0] mask;
    logic [31:0] got;
    case (r)
      REG_CONVERSION: mask = 32'h7;
      REG_MAX_WIDTH:  mask = 32'h3F;
      default:        mask = 32'h1;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (r)
      REG_CONVERSION: cfg_conv  = data[2:0];
      REG_MAX_WIDTH:  cfg_width = data[5:0];
      REG_HALF_SIZE:  cfg_half  = data[0];
      default:        cfg_supp  = data[0];
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if ((got & mask) !== (data & mask)) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("register %s read back: expected %h actual %h", r.name(), data & mask, got);
      end
    end
  endtask

  task automatic configure(input logic [2:0] conv, input logic [5:0] width,
                           input logic half, input logic supp);
    wait_idle();
    reg_write(REG_CONVERSION, 32'(conv));
    reg_write(REG_MAX_WIDTH, 32'(width));
    reg_write(REG_HALF_SIZE, 32'(half));
    reg_write(REG_SUPPRESS, 32'(supp));
  endtask

  // signs, prefixes, terminators, wraparound, truncation, suppression
  task automatic test_directed_fields();
    configure(CONV_SDEC, 6'd0, 1'b0, 1'b0);
    send_text("-9/");
    send_text("+");           // sign with no digit, NUL pushed back
    send_char(8'h00, 1'b0);
    configure(CONV_AUTO, 6'd0, 1'b0, 1'b0);
    send_text("0x");          // bare hex prefix reads as zero
    send_eof();
    send_text("017");         // leading zero selects octal
    send_char(8'hFF, 1'b0);
    configure(CONV_OCT, 6'd0, 1'b0, 1'b0);
    send_text("08");
    configure(CONV_HEX, 6'd2, 1'b0, 1'b0);
    send_text("fF");          // ends on the width limit
    configure(CONV_UDEC, 6'd0, 1'b1, 1'b0);
    send_text("-1");          // wraps, then cut to 16 bits
    send_eof();
    configure(CONV_SDEC, 6'd0, 1'b0, 1'b1);
    send_text("5");
    send_eof();
  endtask

  // width limit dropped under a field that is still open
  task automatic test_width_change_mid_field();
    configure(CONV_SDEC, 6'd0, 1'b0, 1'b0);
    send_text("12");
    wait_idle();
    reg_write(REG_MAX_WIDTH, 32'd1);
    send_text("3");
  endtask

  task automatic pick_random_setting();
    logic [5:0] w;
    case ($urandom_range(0, 9))
      0, 1, 2: w = 6'd0;
      3:       w = 6'd1;
      4:       w = 6'(FIELD_MAX);
      5:       w = 6'($urandom_range(FIELD_MAX + 1, 63));
      default: w = 6'($urandom_range(2, 12));
    endcase
    configure(3'($urandom_range(CONV_SDEC, CONV_SPARE_HI)), w,
              $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  // one field: mostly well formed, some range edges, some noise
  task automatic send_field();
    int kind;
    int ndig;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      repeat ($urandom_range(1, 5)) send_char(8'($urandom), $urandom_range(0, 7) == 0);
    end else begin
      case ($urandom_range(0, 3))
        0:       send_char(CH_PLUS, 1'b0);
        1:       send_char(CH_MINUS, 1'b0);
        default: ;
      endcase
      if (kind <= 3) begin
        send_text(range_literal($urandom_range(0, 7)));
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          send_char(CH_ZERO, 1'b0);
          if ($urandom_range(0, 1) == 1) send_char($urandom_range(0, 1) ? CH_X_LO : CH_X_UP, 1'b0);
        end
        ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 6);
        repeat (ndig) send_char(digit_char(), 1'b0);
      end
      case ($urandom_range(0, 9))
        0:       ;
        1, 2, 3: send_eof();
        default: send_char(8'($urandom), 1'b0);
      endcase
    end
  endtask

  task automatic test_random_fields(input int n_chars);
    int stop_at;
    int fields_left;
    stop_at = sent_chars + n_chars;
    fields_left = 0;
    while (sent_chars < stop_at) begin
      if (fields_left == 0) begin
        pick_random_setting();
        fields_left = $urandom_range(4, 12);
      end
      send_field();
      fields_left--;
    end
  endtask

  // receiver holds off while short fields keep coming, filling the block
  task automatic test_backpressure();
    configure(CONV_UDEC, 6'd0, 1'b0, 1'b0);
    hold_request = HOLD_CYCLES;
    repeat (30) begin
      send_char(digit_char(), 1'b0);
      send_char(" ", 1'b0);
    end
  endtask

  // result side ready: segments of random patterns, plus requested hold-offs
  initial begin : receiver
    stall_mode_t mode;
    int seg_left;
    int held;
    mode = STALL_NONE;
    seg_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
        out_if.ready <= 1'b0;
        repeat (held) @(posedge clk);
      end
      if (seg_left == 0) begin
        mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_TOGGLE));
        seg_left = $urandom_range(10, 60);
      end
      seg_left--;
      case (mode)
        STALL_NONE:  out_if.ready <= 1'b1;
        STALL_LIGHT: out_if.ready <= ($urandom_range(0, 3) != 0);
        STALL_HEAVY: out_if.ready <= ($urandom_range(0, 1) == 1);
        default:     out_if.ready <= ~out_if.ready;
      endcase
    end
  end

  // compare each accepted result word with the oldest expected one
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.value         = out_if.value;
      got.failed        = out_if.failed;
      got.stored        = out_if.stored;
      got.char_returned = out_if.char_returned;
      got.chars_used    = out_if.chars_used;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected result word: value=%h failed=%b stored=%b returned=%b used=%0d",
                   got.value, got.failed, got.stored, got.char_returned, got.chars_used);
        end
      end else begin
        want = expected_results.pop_front();
        if (got.value !== want.value || got.failed !== want.failed ||
            got.stored !== want.stored || got.char_returned !== want.char_returned ||
            got.chars_used !== want.chars_used) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result word at %0t: expected value=%h failed=%b stored=%b returned=%b used=%0d",
                     $realtime, want.value, want.failed, want.stored, want.char_returned,
                     want.chars_used);
            $display("  actual value=%h failed=%b stored=%b returned=%b used=%0d",
                     got.value, got.failed, got.stored, got.char_returned, got.chars_used);
          end
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : main
    in_if.valid        <= 1'b0;
    in_if.char_code    <= 8'h00;
    in_if.end_of_input <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    cfg_conv  = CONV_SDEC;
    cfg_width = '0;
    cfg_half  = 1'b0;
    cfg_supp  = 1'b0;
    start_field();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_fields();
    test_width_change_mid_field();
    test_random_fields(360);
    test_backpressure();

    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
